[hdl/sise_pkg.sv]
// Shared types, constants and codes of the sorted identifier set engine.
`timescale 1ns / 1ps
package sise_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int VAL_W    = 32;
  localparam int IDX_W    = 6;
  localparam int CNT_OUT_W = 7;
  localparam int CMP_W    = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_REMOVE = 2'd1,
    FN_READ   = 2'd2,
    FN_NOP    = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DUP     = 3'd1,
    ST_FULL    = 3'd2,
    ST_MISSING = 3'd3,
    ST_RANGE   = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SRCH_CHK,
    S_SRCH_CMP,
    S_INS_CHK,
    S_INS_WR,
    S_REM_CHK,
    S_REM_WR,
    S_RD_WAIT
  } state_e;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_INC,
    PTR_DEC,
    PTR_COUNT
  } ptr_op_e;

  typedef enum logic [1:0] {
    RA_PTR,
    RA_PTR_M1,
    RA_PTR_P1,
    RA_INDEX
  } rd_addr_e;

  typedef enum logic {
    WR_SHIFT,
    WR_VALUE
  } wr_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  typedef struct packed {
    logic [1:0]              func;
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        index;
  } req_t;

  typedef struct packed {
    logic [CNT_OUT_W-1:0]    count;
    logic signed [VAL_W-1:0] read_value;
    logic [2:0]              status;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic     load;
    ptr_op_e  ptr_op;
    logic     pos_load;
    logic     rd_en;
    rd_addr_e rd_sel;
    logic     wr_en;
    wr_sel_e  wr_sel;
    cnt_op_e  cnt_op;
    logic     res_en;
    logic     res_rd;
    status_e  res_status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] func;
    logic       ptr_at_count;
    logic       ptr_at_pos;
    logic       ptr_p1_lt_count;
    logic       key_lt;
    logic       key_eq;
    logic       full;
    logic       index_ok;
  } sts_t;

endpackage

[hdl/sise_datapath.sv]
// Datapath: element store, pointers, count and result register.
`timescale 1ns / 1ps
module sise_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sise_pkg::cmd_t  cmd_i,
  input  sise_pkg::req_t  req_i,
  output sise_pkg::sts_t  sts_o,
  output logic            done_o,
  output sise_pkg::rsp_t  rsp_o
);

  logic [sise_pkg::VAL_W-1:0]  mem [sise_pkg::CAPACITY];

  sise_pkg::req_t              req_q;
  logic [sise_pkg::CNT_W-1:0]  count_q, count_d;
  logic [sise_pkg::CNT_W-1:0]  ptr_q, ptr_d;
  logic [sise_pkg::CNT_W-1:0]  pos_q;
  logic [sise_pkg::CNT_W-1:0]  ptr_m1, ptr_p1;
  logic signed [sise_pkg::VAL_W-1:0] rd_data_q;
  logic [sise_pkg::ADDR_W-1:0] rd_addr, wr_addr;
  logic [sise_pkg::VAL_W-1:0]  wr_data;
  logic                        done_q;
  sise_pkg::rsp_t              rsp_q;

  assign ptr_m1 = ptr_q - sise_pkg::CNT_W'(1);
  assign ptr_p1 = ptr_q + sise_pkg::CNT_W'(1);

  always_comb begin
    case (cmd_i.ptr_op)
      sise_pkg::PTR_ZERO:  ptr_d = '0;
      sise_pkg::PTR_INC:   ptr_d = ptr_p1;
      sise_pkg::PTR_DEC:   ptr_d = ptr_m1;
      sise_pkg::PTR_COUNT: ptr_d = count_q;
      default:             ptr_d = ptr_q;
    endcase
  end

  always_comb begin
    case (cmd_i.cnt_op)
      sise_pkg::CNT_INC: count_d = count_q + sise_pkg::CNT_W'(1);
      sise_pkg::CNT_DEC: count_d = count_q - sise_pkg::CNT_W'(1);
      default:           count_d = count_q;
    endcase
  end

  always_comb begin
    case (cmd_i.rd_sel)
      sise_pkg::RA_PTR_M1: rd_addr = ptr_m1[sise_pkg::ADDR_W-1:0];
      sise_pkg::RA_PTR_P1: rd_addr = ptr_p1[sise_pkg::ADDR_W-1:0];
      sise_pkg::RA_INDEX:  rd_addr = sise_pkg::ADDR_W'(req_q.index);
      default:             rd_addr = ptr_q[sise_pkg::ADDR_W-1:0];
    endcase
  end

  assign wr_addr = ptr_q[sise_pkg::ADDR_W-1:0];
  assign wr_data = (cmd_i.wr_sel == sise_pkg::WR_VALUE) ? req_q.value : rd_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.pos_load) begin
      pos_q <= ptr_q;
    end
    if (cmd_i.res_en) begin
      rsp_q.count      <= sise_pkg::CNT_OUT_W'(count_d);
      rsp_q.read_value <= cmd_i.res_rd ? rd_data_q : '0;
      rsp_q.status     <= cmd_i.res_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ptr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      ptr_q   <= ptr_d;
      done_q  <= cmd_i.res_en;
    end
  end

  assign sts_o.func            = req_q.func;
  assign sts_o.ptr_at_count    = (ptr_q == count_q);
  assign sts_o.ptr_at_pos      = (ptr_q == pos_q);
  assign sts_o.ptr_p1_lt_count = (ptr_p1 < count_q);
  assign sts_o.key_lt          = (rd_data_q < req_q.value);
  assign sts_o.key_eq          = (rd_data_q == req_q.value);
  assign sts_o.full            = (count_q >= sise_pkg::CNT_W'(sise_pkg::CAPACITY));
  assign sts_o.index_ok        = (sise_pkg::CMP_W'(req_q.index) < sise_pkg::CMP_W'(count_q));

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

[hdl/sise_ctrl.sv]
// Controller: sequences search, shift and read steps over the element store.
`timescale 1ns / 1ps
module sise_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  sise_pkg::sts_t  sts_i,
  output sise_pkg::cmd_t  cmd_o
);

  sise_pkg::state_e state_q, state_d;
  logic             is_ins, is_rem, is_rd;

  assign is_ins = (sts_i.func == sise_pkg::FN_INSERT);
  assign is_rem = (sts_i.func == sise_pkg::FN_REMOVE);
  assign is_rd  = (sts_i.func == sise_pkg::FN_READ);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sise_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sise_pkg::S_IDLE: begin
        if (start) state_d = sise_pkg::S_DISPATCH;
      end
      sise_pkg::S_DISPATCH: begin
        if (is_ins || is_rem)              state_d = sise_pkg::S_SRCH_CHK;
        else if (is_rd && sts_i.index_ok)  state_d = sise_pkg::S_RD_WAIT;
        else                               state_d = sise_pkg::S_IDLE;
      end
      sise_pkg::S_SRCH_CHK: begin
        if (!sts_i.ptr_at_count)            state_d = sise_pkg::S_SRCH_CMP;
        else if (is_ins && !sts_i.full)     state_d = sise_pkg::S_INS_CHK;
        else                                state_d = sise_pkg::S_IDLE;
      end
      sise_pkg::S_SRCH_CMP: begin
        if (sts_i.key_lt)                   state_d = sise_pkg::S_SRCH_CHK;
        else if (sts_i.key_eq)              state_d = is_rem ? sise_pkg::S_REM_CHK
                                                             : sise_pkg::S_IDLE;
        else if (is_ins && !sts_i.full)     state_d = sise_pkg::S_INS_CHK;
        else                                state_d = sise_pkg::S_IDLE;
      end
      sise_pkg::S_INS_CHK: begin
        state_d = sts_i.ptr_at_pos ? sise_pkg::S_IDLE : sise_pkg::S_INS_WR;
      end
      sise_pkg::S_INS_WR:  state_d = sise_pkg::S_INS_CHK;
      sise_pkg::S_REM_CHK: begin
        state_d = sts_i.ptr_p1_lt_count ? sise_pkg::S_REM_WR : sise_pkg::S_IDLE;
      end
      sise_pkg::S_REM_WR:  state_d = sise_pkg::S_REM_CHK;
      sise_pkg::S_RD_WAIT: state_d = sise_pkg::S_IDLE;
      default:             state_d = sise_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      sise_pkg::S_IDLE: begin
        if (start) begin
          cmd_o.load   = 1'b1;
          cmd_o.ptr_op = sise_pkg::PTR_ZERO;
        end
      end
      sise_pkg::S_DISPATCH: begin
        if (is_rd) begin
          if (sts_i.index_ok) begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = sise_pkg::RA_INDEX;
          end else begin
            cmd_o.res_en     = 1'b1;
            cmd_o.res_status = sise_pkg::ST_RANGE;
          end
        end else if (!is_ins && !is_rem) begin
          cmd_o.res_en     = 1'b1;
          cmd_o.res_status = sise_pkg::ST_OK;
        end
      end
      sise_pkg::S_SRCH_CHK: begin
        if (!sts_i.ptr_at_count) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = sise_pkg::RA_PTR;
        end else if (is_ins && !sts_i.full) begin
          cmd_o.pos_load = 1'b1;
          cmd_o.ptr_op   = sise_pkg::PTR_COUNT;
        end else begin
          cmd_o.res_en     = 1'b1;
          cmd_o.res_status = is_ins ? sise_pkg::ST_FULL : sise_pkg::ST_MISSING;
        end
      end
      sise_pkg::S_SRCH_CMP: begin
        if (sts_i.key_lt) begin
          cmd_o.ptr_op = sise_pkg::PTR_INC;
        end else if (sts_i.key_eq) begin
          if (!is_rem) begin
            cmd_o.res_en     = 1'b1;
            cmd_o.res_status = sise_pkg::ST_DUP;
          end
        end else if (is_ins && !sts_i.full) begin
          cmd_o.pos_load = 1'b1;
          cmd_o.ptr_op   = sise_pkg::PTR_COUNT;
        end else begin
          cmd_o.res_en     = 1'b1;
          cmd_o.res_status = is_ins ? sise_pkg::ST_FULL : sise_pkg::ST_MISSING;
        end
      end
      sise_pkg::S_INS_CHK: begin
        if (sts_i.ptr_at_pos) begin
          cmd_o.wr_en      = 1'b1;
          cmd_o.wr_sel     = sise_pkg::WR_VALUE;
          cmd_o.cnt_op     = sise_pkg::CNT_INC;
          cmd_o.res_en     = 1'b1;
          cmd_o.res_status = sise_pkg::ST_OK;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = sise_pkg::RA_PTR_M1;
        end
      end
      sise_pkg::S_INS_WR: begin
        // move the element below up by one slot
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = sise_pkg::WR_SHIFT;
        cmd_o.ptr_op = sise_pkg::PTR_DEC;
      end
      sise_pkg::S_REM_CHK: begin
        if (sts_i.ptr_p1_lt_count) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = sise_pkg::RA_PTR_P1;
        end else begin
          cmd_o.cnt_op     = sise_pkg::CNT_DEC;
          cmd_o.res_en     = 1'b1;
          cmd_o.res_status = sise_pkg::ST_OK;
        end
      end
      sise_pkg::S_REM_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = sise_pkg::WR_SHIFT;
        cmd_o.ptr_op = sise_pkg::PTR_INC;
      end
      sise_pkg::S_RD_WAIT: begin
        cmd_o.res_en     = 1'b1;
        cmd_o.res_rd     = 1'b1;
        cmd_o.res_status = sise_pkg::ST_OK;
      end
      default: cmd_o = '0;
    endcase
  end

  assign busy = (state_q != sise_pkg::S_IDLE);

endmodule

[hdl/sorted_id_set_engine_top.sv]
// Top level of the sorted identifier set engine.
`timescale 1ns / 1ps
// Keeps an ascending, duplicate-free set of signed 32-bit identifiers in a
// 64-entry store and serves one request at a time: insert, remove, or read
// at an index. A request is taken when start is high and busy is low; in the
// cycle after the last step the result shows for a single cycle with done_o
// high, and it must be captured then, as the block cannot be stalled. The
// store has one read and one write port with a registered read, and insert
// and remove scan it linearly and then shift elements one slot at a time.
// busy falls in the cycle the result is shown, so a new request can follow
// directly. No clearing pass follows reset.
module sorted_id_set_engine_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  sise_pkg::req_t  req_i,
  output logic            done_o,
  output sise_pkg::rsp_t  rsp_o
);

  sise_pkg::cmd_t cmd;
  sise_pkg::sts_t sts;

  sise_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  sise_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .sts_o  (sts),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule

[verif/sise_scoreboard_pkg.sv]
// Scoreboard class for the sorted identifier set engine testbench.
`timescale 1ns / 1ps
package sise_scoreboard_pkg;

  import sise_pkg::*;

  class id_set_scoreboard;

    // Own copy of the set, ascending, valid below set_size
    logic signed [VAL_W-1:0] set_elems [CAPACITY];
    int                      set_size;
    int                      peak_size;
    rsp_t                    expected_rsps [$];
    int                      errors;
    int                      status_hits [5];

    function new();
      foreach (set_elems[i]) set_elems[i] = '0;
      foreach (status_hits[i]) status_hits[i] = 0;
      set_size  = 0;
      peak_size = 0;
      errors    = 0;
    endfunction

    // first slot whose element is not less than v
    function int lower_slot(logic signed [VAL_W-1:0] v);
      int pos;
      pos = 0;
      while (pos < set_size && set_elems[pos] < v) pos++;
      return pos;
    endfunction

    function void note_request(req_t rq);
      rsp_t                    want;
      status_e                 st;
      logic signed [VAL_W-1:0] rd;
      int                      pos;
      int                      i;
      st = ST_OK;
      rd = '0;
      case (func_e'(rq.func))
        FN_INSERT: begin
          pos = lower_slot(rq.value);
          if (pos < set_size && set_elems[pos] == rq.value) begin
            st = ST_DUP;
          end else if (set_size >= CAPACITY) begin
            st = ST_FULL;
          end else begin
            for (i = set_size; i > pos; i--) set_elems[i] = set_elems[i-1];
            set_elems[pos] = rq.value;
            set_size++;
          end
        end
        FN_REMOVE: begin
          pos = lower_slot(rq.value);
          if (pos < set_size && set_elems[pos] == rq.value) begin
            for (i = pos; i + 1 < set_size; i++) set_elems[i] = set_elems[i+1];
            set_size--;
          end else begin
            st = ST_MISSING;
          end
        end
        FN_READ: begin
          if (int'(rq.index) < set_size) rd = set_elems[rq.index];
          else st = ST_RANGE;
        end
        default: ;
      endcase
      if (set_size > peak_size) peak_size = set_size;
      want.count      = CNT_OUT_W'(set_size);
      want.read_value = rd;
      want.status     = st;
      status_hits[int'(st)]++;
      expected_rsps.push_back(want);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (expected_rsps.size() == 0) begin
        errors++;
        $display("%0t: result with nothing outstanding: count %0d read_value %0d status %0d",
                 $time, got.count, got.read_value, got.status);
        return;
      end
      want = expected_rsps.pop_front();
      if (got.count !== want.count) begin
        errors++;
        $display("%0t: count mismatch: expected %0d actual %0d",
                 $time, want.count, got.count);
      end
      if (got.read_value !== want.read_value) begin
        errors++;
        $display("%0t: read_value mismatch: expected %0d actual %0d",
                 $time, want.read_value, got.read_value);
      end
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status mismatch: expected %0d actual %0d",
                 $time, want.status, got.status);
      end
    endfunction

    function int pending();
      return expected_rsps.size();
    endfunction

    function void note_leftover();
      if (expected_rsps.size() != 0) begin
        errors += expected_rsps.size();
        $display("%0t: %0d results never arrived", $time, expected_rsps.size());
      end
    endfunction

  endclass

endpackage

[verif/tb_sorted_id_set_engine_top.sv]
// Randomised self-checking testbench for sorted_id_set_engine_top.
`timescale 1ns / 1ps
module tb_sorted_id_set_engine_top;

  import sise_pkg::*;
  import sise_scoreboard_pkg::*;

  localparam int TOTAL_REQS  = 1425;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYC  = 20;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED, PH_DENSE} phase_e;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req;
  logic done;
  rsp_t rsp;

  id_set_scoreboard sb;
  int               sent;
  int               directed_cnt;
  int               stall_cnt;
  bit               burst;

  sorted_id_set_engine_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req),
    .done_o (done),
    .rsp_o  (rsp)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // result checked before the request taken on the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done) sb.check_response(rsp);
      if (start && !busy) sb.note_request(req);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done) begin
        stall_cnt <= 0;
      end else if (stall_cnt + 1 >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("tb_sorted_id_set_engine_top: FAIL");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value(int member_pct);
    int k;
    if (sb.set_size > 0 && $urandom_range(0, 99) < member_pct)
      return sb.set_elems[$urandom_range(0, sb.set_size - 1)];
    k = $urandom_range(0, 9);
    if (k < 5) return $urandom;
    if (k < 8) return int'($urandom_range(0, 16)) - 8;
    if (k == 8) return {1'b1, 31'($urandom_range(0, 3))};
    return 32'h7fff_ffff - $urandom_range(0, 3);
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    if (sb.set_size > 0 && $urandom_range(0, 99) < 80)
      return IDX_W'($urandom_range(0, sb.set_size - 1));
    return IDX_W'($urandom_range(0, 63));
  endfunction

  // all tasks enter and leave at a falling edge
  task automatic idle_for(input int n);
    req_t noise;
    if (n > 0) begin
      noise.func  = 2'($urandom);
      noise.value = $urandom;
      noise.index = IDX_W'($urandom);
      start <= 1'b0;
      req   <= noise;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic send_req(input func_e f, input logic signed [VAL_W-1:0] v,
                          input logic [IDX_W-1:0] ix);
    req_t rq;
    rq.func  = f;
    rq.value = v;
    rq.index = ix;
    start <= 1'b1;
    req   <= rq;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
    idle_for(gap_len());
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic run_phase(input phase_e ph);
    int n;
    int r;
    case (ph)
      PH_FILL: begin
        n = 0;
        while (sb.set_size < CAPACITY && n < 200) begin
          send_req(FN_INSERT, pick_value(10), IDX_W'($urandom));
          n++;
        end
        // full store: new values dropped, members still reported duplicate
        repeat (16) send_req(FN_INSERT, pick_value(40), IDX_W'($urandom));
        repeat (4) send_req(FN_READ, $urandom, IDX_W'($urandom_range(32, 63)));
      end
      PH_DRAIN: begin
        // set difference: stream the subtrahend as removes
        n = 0;
        while (sb.set_size > 0 && n < 150) begin
          if ($urandom_range(0, 99) < 85)
            send_req(FN_REMOVE, pick_value(75), IDX_W'($urandom));
          else send_req(FN_READ, $urandom, pick_index());
          n++;
        end
      end
      PH_MIXED: begin
        repeat (80) begin
          r = $urandom_range(0, 99);
          if (r < 35) send_req(FN_INSERT, pick_value(30), IDX_W'($urandom));
          else if (r < 65) send_req(FN_REMOVE, pick_value(60), IDX_W'($urandom));
          else if (r < 95) send_req(FN_READ, $urandom, pick_index());
          else send_req(FN_NOP, $urandom, IDX_W'($urandom));
        end
      end
      default: begin
        // narrow value range, so hits and misses are dense
        repeat (60) begin
          r = $urandom_range(0, 2);
          send_req(func_e'(r), int'($urandom_range(0, 16)) - 8, pick_index());
        end
      end
    endcase
  endtask

  initial begin
    phase_e ph;
    bit     first;
    sb        = new();
    sent      = 0;
    stall_cnt = 0;
    burst     = 1'b0;
    start     = 1'b0;
    req       = '0;
    rst_ni    = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed
    send_req(FN_READ,   '0, '0);                 // read on empty store
    send_req(FN_REMOVE, 32'sd5, '0);             // remove from empty store
    send_req(FN_NOP,    32'h1234_5678, 6'h3f);   // unused code
    send_req(FN_INSERT, 32'sd0, '0);
    send_req(FN_INSERT, 32'h7fff_ffff, '0);
    send_req(FN_INSERT, 32'h7fff_ffff, '0);      // duplicate of the last element
    send_req(FN_INSERT, 32'h8000_0000, '0);
    send_req(FN_INSERT, 32'h8000_0000, '0);      // duplicate of the first element
    send_req(FN_INSERT, -32'sd1, '0);
    send_req(FN_INSERT, 32'sd1, '0);
    send_req(FN_READ,   '0, 6'd0);
    send_req(FN_READ,   '0, 6'd4);
    send_req(FN_READ,   '0, 6'd5);               // index equal to count
    send_req(FN_READ,   '0, 6'd63);
    send_req(FN_REMOVE, 32'sd0, '0);
    send_req(FN_REMOVE, 32'sd0, '0);             // now absent
    send_req(FN_REMOVE, 32'h7fff_ffff, '0);
    send_req(FN_INSERT, 32'h7fff_fffe, '0);
    send_req(FN_INSERT, 32'h7fff_ffff, '0);
    send_req(FN_REMOVE, 32'h8000_0000, '0);
    send_req(FN_NOP,    32'hffff_ffff, 6'h2a);
    send_req(FN_INSERT, 32'sd0, '0);
    send_req(FN_INSERT, 32'sd0, '0);
    send_req(FN_REMOVE, 32'h7fff_ffff, '0);
    send_req(FN_READ,   '0, 6'd3);
    directed_cnt = sent;

    // random phases, the first one fills the store
    ph    = PH_FILL;
    first = 1'b1;
    while (sent < TOTAL_REQS) begin
      run_phase(ph);
      if (first || $urandom_range(0, 2) == 0) wait_drained();
      first = 1'b0;
      ph    = phase_e'($urandom_range(0, 3));
      burst = ($urandom_range(0, 3) == 0);
    end

    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk_i);
    sb.note_leftover();
    $display("Sent %0d requests (%0d directed), peak set size %0d of %0d.",
             sent, directed_cnt, sb.peak_size, CAPACITY);
    $display("Status mix: ok %0d, duplicate %0d, full %0d, not found %0d, out of range %0d.",
             sb.status_hits[0], sb.status_hits[1], sb.status_hits[2],
             sb.status_hits[3], sb.status_hits[4]);
    if (sb.errors == 0) begin
      $display("tb_sorted_id_set_engine_top: PASS");
    end else begin
      $display("tb_sorted_id_set_engine_top: FAIL");
    end
    $finish;
  end

endmodule
